// ===== src/grc_pkg.sv =====
// Shared types, constants and helpers of the grid raycast column renderer.
`timescale 1ns / 1ps
package grc_pkg;

  // Shared divider word width
  localparam int DivW = 32;
  // Signed walk coordinate width: covers the start cell plus up to 128 steps either way
  localparam int CoordW = 10;
  // Side distance width: 128 steps of at most 2^30 each
  localparam int SideW = 40;
  // Signed ray component width, Q2.14 plus two bits of growth
  localparam int RayW = 18;

  localparam logic [15:0] ColorRed    = 16'hF800;
  localparam logic [15:0] ColorGreen  = 16'h07E0;
  localparam logic [15:0] ColorBlue   = 16'h001F;
  localparam logic [15:0] ColorWhite  = 16'hFFFF;
  localparam logic [15:0] ColorYellow = 16'hFFE0;

  typedef enum logic [2:0] {
    REG_POS_X    = 3'd0,
    REG_POS_Y    = 3'd1,
    REG_DIR_X    = 3'd2,
    REG_DIR_Y    = 3'd3,
    REG_PLANE_X  = 3'd4,
    REG_PLANE_Y  = 3'd5,
    REG_STRIPE_W = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic        [20:0] pos_x;
    logic        [20:0] pos_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] plane_x;
    logic signed [15:0] plane_y;
    logic        [3:0]  stripe_width;
  } cfg_t;

  // Request passed from the front to the back
  typedef struct packed {
    logic       is_cast;
    logic [8:0] column;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
    logic [2:0] value;
  } cmd_t;

  typedef struct packed {
    logic [8:0]  x_start;
    logic [8:0]  x_end;
    logic [7:0]  y_start;
    logic [7:0]  y_end;
    logic [15:0] color;
    logic        last;
  } rect_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CAST,
    S_RAY,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SIDE_X,
    S_SIDE_Y,
    S_STEP,
    S_LOOK,
    S_NUM,
    S_ROWS,
    S_PLAN,
    S_OUT
  } bk_state_e;

  typedef enum logic [2:0] {
    DIV_DX,
    DIV_DY,
    DIV_LH
  } div_op_e;

  function automatic logic [15:0] wall_color(logic [2:0] wall, logic y_side);
    logic [15:0] c;
    case (wall)
      3'd1:    c = ColorRed;
      3'd2:    c = ColorGreen;
      3'd3:    c = ColorBlue;
      3'd4:    c = ColorWhite;
      default: c = ColorYellow;
    endcase
    return y_side ? (c >> 1) : c;
  endfunction

endpackage

// ===== src/grc_fifo.sv =====
// Small register queue used between front and back and on the result side.
`timescale 1ns / 1ps
module grc_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  localparam int PtrW = $clog2(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [PtrW:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW + 1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

// ===== src/grc_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module grc_div
  import grc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DivW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] quotient_o
);
  localparam int CntW = $clog2(DivW + 1);

  logic [DivW-1:0] rem_q, quo_q, dvs_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DivW:0]   trial;
  logic            ge;

  assign trial      = {rem_q, quo_q[DivW-1]};
  assign ge         = trial >= {1'b0, dvs_q};
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? DivW'(trial - {1'b0, dvs_q}) : trial[DivW-1:0];
      quo_q <= {quo_q[DivW-2:0], ge};
    end
  end

endmodule

// ===== src/grc_front.sv =====
// Front: configuration registers, request intake and classification.
`timescale 1ns / 1ps
module grc_front
  import grc_pkg::*;
#(
  parameter int MAP_SIZE     = 32,
  parameter int SCREEN_WIDTH = 320
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [20:0] cfg_data_i,
  output cfg_t        cfg_o,
  input  logic        push,
  output logic        full,
  input  logic        action_i,
  input  logic [8:0]  column_i,
  input  logic [4:0]  cell_x_i,
  input  logic [4:0]  cell_y_i,
  input  logic [2:0]  cell_value_i,
  input  logic        clearing_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output cmd_t        q_data_o
);
  cfg_t cfg_q;
  logic keep;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;
  assign full        = q_full_i || clearing_i;

  // Drop off-screen casts and off-map writes here
  assign keep = action_i ? (int'(column_i) < SCREEN_WIDTH)
                         : (int'(cell_x_i) < MAP_SIZE) && (int'(cell_y_i) < MAP_SIZE);
  assign q_push_o = push && !full && keep;
  assign q_data_o = '{is_cast: action_i, column: column_i, cell_x: cell_x_i,
                      cell_y: cell_y_i, value: cell_value_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_x        <= 21'd1441792;
      cfg_q.pos_y        <= 21'd786432;
      cfg_q.dir_x        <= -16'sd16384;
      cfg_q.dir_y        <= '0;
      cfg_q.plane_x      <= '0;
      cfg_q.plane_y      <= 16'sd10813;
      cfg_q.stripe_width <= 4'd2;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_POS_X:    cfg_q.pos_x        <= cfg_data_i;
        REG_POS_Y:    cfg_q.pos_y        <= cfg_data_i;
        REG_DIR_X:    cfg_q.dir_x        <= cfg_data_i[15:0];
        REG_DIR_Y:    cfg_q.dir_y        <= cfg_data_i[15:0];
        REG_PLANE_X:  cfg_q.plane_x      <= cfg_data_i[15:0];
        REG_PLANE_Y:  cfg_q.plane_y      <= cfg_data_i[15:0];
        REG_STRIPE_W: cfg_q.stripe_width <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/grc_back.sv =====
// Back: map and stripe memories, ray setup, DDA walk, line height and rectangle output.
`timescale 1ns / 1ps
module grc_back
  import grc_pkg::*;
#(
  parameter int MAP_SIZE      = 32,
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  cmd_t  cmd_i,
  input  logic  cmd_empty_i,
  output logic  cmd_pop_o,
  output rect_t rect_o,
  output logic  rect_push_o,
  input  logic  rect_full_i,
  output logic  clearing_o
);
  localparam int MapCells = MAP_SIZE * MAP_SIZE;
  localparam int MapAW    = $clog2(MapCells);
  localparam int ColW     = $clog2(SCREEN_WIDTH);
  localparam int RowW     = $clog2(SCREEN_HEIGHT);
  localparam int LhW      = $clog2(2 * SCREEN_HEIGHT + 1);
  localparam int ClrN     = (MapCells > SCREEN_WIDTH) ? MapCells : SCREEN_WIDTH;
  localparam int ClrW     = $clog2(ClrN);
  localparam int StepN    = 2 * MAP_SIZE;
  localparam int StepW    = $clog2(StepN + 1);
  localparam int CamW     = ColW + 2;
  localparam int ProdW    = CamW + 16;
  localparam int NumW     = CoordW + 17;
  localparam int StW      = 2 * RowW + 16;
  localparam int HalfH    = SCREEN_HEIGHT / 2;
  // Reciprocal of the screen width: exact floor for any |plane * cam|
  localparam int     RecK  = ProdW - 1 + ColW;
  localparam int     RecMW = RecK - ColW + 2;
  localparam int     RecPW = ProdW - 1 + RecMW;
  localparam longint RecM  = ((longint'(1) << RecK) + longint'(SCREEN_WIDTH) - 1)
                             / longint'(SCREEN_WIDTH);

  bk_state_e state_q, state_d;
  div_op_e   op_q, op_d;
  logic [ClrW-1:0] clr_q;

  logic [2:0]     map_mem [MapCells];
  logic [StW-1:0] st_mem  [SCREEN_WIDTH];
  logic [2:0]     map_rd_q;
  logic [StW-1:0] st_rd_q;

  logic [ColW-1:0]               col_q;
  logic signed [ProdW-1:0]       prodx_q, prody_q;
  logic signed [RayW-1:0]        rx_q, ry_q;
  logic [30:0]                   dx_q, dy_q;
  logic [SideW-1:0]              sdx_q, sdy_q;
  logic                          xinf_q, yinf_q;
  logic signed [CoordW-1:0]      mx_q, my_q;
  logic                          side_q, inmap_q;
  logic [StepW-1:0]              n_q;
  logic [2:0]                    cell_q;
  logic [NumW-1:0]               anum_q;
  logic [RayW-2:0]               aray_q;
  logic [LhW-1:0]                lh_q;
  logic [RowW-1:0]               st_q, en_q;
  logic [15:0]                   color_q;
  logic [RowW-1:0]               rs_q [3];
  logic [RowW-1:0]               re_q [3];
  logic [15:0]                   rc_q [3];
  logic [1:0]                    k_q, idx_q;

  // Divider
  logic            div_start, div_done;
  logic [DivW-1:0] div_a, div_b, div_q;

  // Combinational helpers
  logic signed [CamW-1:0] cam;
  logic [ProdW-1:0]       absx, absy;
  logic [RecPW-1:0]       recx, recy;
  logic                   rx_neg, ry_neg;
  logic [RayW-1:0]        rxa, rya;
  logic [RayW-2:0]        arx, ary;
  logic signed [RayW-1:0] qx_s, qy_s;
  logic [16:0]            fx, fy;
  logic [47:0]            sprod_x, sprod_y;
  logic                   stepx;
  logic signed [CoordW-1:0] nmx, nmy, edge_c;
  logic                   n_inmap;
  logic [MapAW-1:0]       walk_addr, cmd_addr;
  logic signed [NumW-1:0] num_c;
  logic [LhW-1:0]         half, lh_c;
  logic [LhW:0]           en_sum;
  logic [RowW-1:0]        st_c, en_c;
  logic [RowW-1:0]        old_s, old_e;
  logic [15:0]            old_c;
  logic [RowW-1:0]        ps [3];
  logic [RowW-1:0]        pe [3];
  logic [15:0]            pc [3];
  logic [1:0]             pk;
  logic                   top_v, bot_v;
  logic [RowW-1:0]        top_s, top_e, bot_s, bot_e;
  logic [15:0]            top_c, bot_c;
  logic                   map_we, map_re, st_we, st_re;
  logic [MapAW-1:0]       map_wa;
  logic [2:0]             map_wd;
  logic [ColW-1:0]        st_a;
  logic [StW-1:0]         st_wd;

  grc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign clearing_o = (state_q == S_CLEAR);
  assign div_start  = (state_q == S_DIV_GO);

  assign cam    = $signed({1'b0, col_q, 1'b0}) - $signed(CamW'(SCREEN_WIDTH));
  assign absx   = prodx_q[ProdW-1] ? ProdW'(-prodx_q) : ProdW'(prodx_q);
  assign absy   = prody_q[ProdW-1] ? ProdW'(-prody_q) : ProdW'(prody_q);
  assign rx_neg = rx_q[RayW-1];
  assign ry_neg = ry_q[RayW-1];
  assign rxa    = rx_neg ? RayW'(-rx_q) : RayW'(rx_q);
  assign rya    = ry_neg ? RayW'(-ry_q) : RayW'(ry_q);
  assign arx    = rxa[RayW-2:0];
  assign ary    = rya[RayW-2:0];

  // Divide |plane * cam| by the screen width through its reciprocal
  assign recx   = RecPW'(absx[ProdW-2:0]) * RecPW'(RecM);
  assign recy   = RecPW'(absy[ProdW-2:0]) * RecPW'(RecM);
  assign qx_s   = $signed(RayW'(recx[RecPW-1:RecK]));
  assign qy_s   = $signed(RayW'(recy[RecPW-1:RecK]));

  always_comb begin
    case (op_q)
      DIV_DX: begin div_a = DivW'(32'h4000_0000); div_b = DivW'(arx); end
      DIV_DY: begin div_a = DivW'(32'h4000_0000); div_b = DivW'(ary); end
      default: begin
        div_a = DivW'(aray_q) * DivW'(4 * SCREEN_HEIGHT);
        div_b = DivW'(anum_q);
      end
    endcase
  end

  // Distance to the next cell edge, Q16
  assign fx      = rx_neg ? {1'b0, cfg_i.pos_x[15:0]} : 17'h10000 - {1'b0, cfg_i.pos_x[15:0]};
  assign fy      = ry_neg ? {1'b0, cfg_i.pos_y[15:0]} : 17'h10000 - {1'b0, cfg_i.pos_y[15:0]};
  assign sprod_x = 48'(fx) * 48'(dx_q);
  assign sprod_y = 48'(fy) * 48'(dy_q);

  // DDA step
  assign stepx   = !xinf_q && (yinf_q || (sdx_q < sdy_q));
  assign nmx     = stepx ? (rx_neg ? mx_q - 2'sd1 : mx_q + 2'sd1) : mx_q;
  assign nmy     = stepx ? my_q : (ry_neg ? my_q - 2'sd1 : my_q + 2'sd1);
  assign n_inmap = !nmx[CoordW-1] && !nmy[CoordW-1]
                   && (int'(nmx) < MAP_SIZE) && (int'(nmy) < MAP_SIZE);
  assign walk_addr = MapAW'(int'(nmx) * MAP_SIZE + int'(nmy));
  assign cmd_addr  = MapAW'(int'(cmd_i.cell_x) * MAP_SIZE + int'(cmd_i.cell_y));

  // Signed distance from the camera to the crossed edge, Q16
  assign edge_c = side_q ? (ry_neg ? my_q + 2'sd1 : my_q) : (rx_neg ? mx_q + 2'sd1 : mx_q);
  assign num_c  = $signed({edge_c[CoordW-1], edge_c, 16'd0})
                  - $signed(NumW'(side_q ? cfg_i.pos_y : cfg_i.pos_x));

  always_comb begin
    if (aray_q == '0) lh_c = '0;
    else if (anum_q == '0) lh_c = LhW'(2 * SCREEN_HEIGHT);
    else if (div_q >= DivW'(2 * SCREEN_HEIGHT)) lh_c = LhW'(2 * SCREEN_HEIGHT);
    else lh_c = LhW'(div_q);
  end

  assign half   = lh_q >> 1;
  assign st_c   = (LhW'(HalfH) > half) ? RowW'(LhW'(HalfH) - half) : '0;
  assign en_sum = (LhW + 1)'(half) + (LhW + 1)'(HalfH);
  assign en_c   = (en_sum >= (LhW + 1)'(SCREEN_HEIGHT)) ? RowW'(SCREEN_HEIGHT - 1)
                                                         : RowW'(en_sum);

  // Rectangle plan against the stored stripe
  assign old_s = st_rd_q[StW-1 -: RowW];
  assign old_e = st_rd_q[16 +: RowW];
  assign old_c = st_rd_q[15:0];

  always_comb begin
    top_v = 1'b0; top_s = st_q; top_e = old_s; top_c = color_q;
    bot_v = 1'b0; bot_s = en_q; bot_e = old_e; bot_c = '0;
    if (st_q < old_s) begin
      top_v = 1'b1;
    end else if (st_q > old_s) begin
      top_v = 1'b1; top_s = old_s; top_e = st_q; top_c = '0;
    end
    if (en_q < old_e) begin
      bot_v = 1'b1;
    end else if (en_q > old_e) begin
      bot_v = 1'b1; bot_s = old_e; bot_e = en_q; bot_c = color_q;
    end
    for (int i = 0; i < 3; i++) begin
      ps[i] = st_q; pe[i] = en_q; pc[i] = color_q;
    end
    pk = 2'd1;
    if ((old_s == '0 && old_e == '0) || (old_c != color_q && st_q <= old_s)) begin
      pk = 2'd1;
    end else if (old_c != color_q) begin
      // Erase above, draw, erase below
      pk = 2'd3;
      ps[0] = old_s; pe[0] = st_q;  pc[0] = '0;
      ps[2] = en_q;  pe[2] = old_e; pc[2] = '0;
      ps[1] = st_q;  pe[1] = en_q;  pc[1] = color_q;
    end else begin
      pk = 2'(top_v) + 2'(bot_v);
      if (top_v) begin
        ps[0] = top_s; pe[0] = top_e; pc[0] = top_c;
        ps[1] = bot_s; pe[1] = bot_e; pc[1] = bot_c;
      end else begin
        ps[0] = bot_s; pe[0] = bot_e; pc[0] = bot_c;
      end
    end
  end

  // Memory ports
  always_comb begin
    map_we = 1'b0; map_wa = cmd_addr; map_wd = cmd_i.value;
    st_we  = 1'b0; st_a = ColW'(cmd_i.column); st_wd = '0;
    map_re = (state_q == S_STEP) && n_inmap;
    st_re  = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        map_we = (int'(clr_q) < MapCells);
        map_wa = MapAW'(clr_q);
        map_wd = '0;
        st_we  = (int'(clr_q) < SCREEN_WIDTH);
        st_a   = ColW'(clr_q);
      end
      S_IDLE: begin
        map_we = !cmd_empty_i && !cmd_i.is_cast;
        st_re  = !cmd_empty_i && cmd_i.is_cast;
      end
      S_PLAN: begin
        st_we = 1'b1;
        st_a  = col_q;
        st_wd = {st_q, en_q, color_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (map_re) map_rd_q <= map_mem[walk_addr];
  end

  always_ff @(posedge clk_i) begin
    if (st_we) st_mem[st_a] <= st_wd;
    if (st_re) st_rd_q <= st_mem[st_a];
  end

  assign cmd_pop_o   = (state_q == S_IDLE) && !cmd_empty_i;
  assign rect_push_o = (state_q == S_OUT) && (idx_q != k_q) && !rect_full_i;
  assign rect_o = '{x_start: 9'(col_q),
                    x_end:   9'(32'(col_q) + 32'(cfg_i.stripe_width)),
                    y_start: 8'(rs_q[idx_q]),
                    y_end:   8'(re_q[idx_q]),
                    color:   rc_q[idx_q],
                    last:    (idx_q == k_q - 2'd1)};

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      S_CLEAR: if (int'(clr_q) == ClrN - 1) state_d = S_IDLE;
      S_IDLE:  if (!cmd_empty_i && cmd_i.is_cast) state_d = S_CAST;
      S_CAST:  state_d = S_RAY;
      S_RAY: begin
        op_d    = DIV_DX;
        state_d = S_DIV_GO;
      end
      S_DIV_GO: state_d = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_done) begin
          unique case (op_q)
            DIV_DX: begin op_d = DIV_DY; state_d = S_DIV_GO; end
            DIV_DY: state_d = S_SIDE_X;
            default: state_d = S_ROWS;
          endcase
        end
      end
      S_SIDE_X: state_d = S_SIDE_Y;
      S_SIDE_Y: state_d = S_STEP;
      S_STEP:   state_d = S_LOOK;
      S_LOOK: begin
        if (!inmap_q || map_rd_q != '0 || int'(n_q) == StepN) state_d = S_NUM;
        else state_d = S_STEP;
      end
      S_NUM: begin
        op_d    = DIV_LH;
        state_d = S_DIV_GO;
      end
      S_ROWS: state_d = S_PLAN;
      S_PLAN: state_d = S_OUT;
      S_OUT:  if (idx_q == k_q) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      op_q    <= DIV_DX;
      clr_q   <= '0;
      k_q     <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == S_PLAN) begin
        k_q   <= pk;
        idx_q <= '0;
      end else if (rect_push_o) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: col_q <= ColW'(cmd_i.column);
      S_CAST: begin
        prodx_q <= ProdW'(cfg_i.plane_x) * ProdW'(cam);
        prody_q <= ProdW'(cfg_i.plane_y) * ProdW'(cam);
      end
      S_RAY: begin
        rx_q <= RayW'(cfg_i.dir_x) + (prodx_q[ProdW-1] ? -qx_s : qx_s);
        ry_q <= RayW'(cfg_i.dir_y) + (prody_q[ProdW-1] ? -qy_s : qy_s);
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          case (op_q)
            DIV_DX: dx_q <= div_q[30:0];
            DIV_DY: dy_q <= div_q[30:0];
            default: lh_q <= lh_c;
          endcase
        end
      end
      S_SIDE_X: begin
        xinf_q <= (arx == '0);
        sdx_q  <= SideW'(sprod_x[47:16]);
        mx_q   <= CoordW'(cfg_i.pos_x[20:16]);
        n_q    <= '0;
      end
      S_SIDE_Y: begin
        yinf_q <= (ary == '0);
        sdy_q  <= SideW'(sprod_y[47:16]);
        my_q   <= CoordW'(cfg_i.pos_y[20:16]);
      end
      S_STEP: begin
        // Advance one cell on the nearer edge
        if (stepx) begin
          sdx_q  <= sdx_q + SideW'(dx_q);
          side_q <= 1'b0;
        end else begin
          if (!yinf_q) sdy_q <= sdy_q + SideW'(dy_q);
          side_q <= 1'b1;
        end
        mx_q    <= nmx;
        my_q    <= nmy;
        inmap_q <= n_inmap;
        n_q     <= n_q + 1'b1;
      end
      S_LOOK: cell_q <= inmap_q ? map_rd_q : 3'd1;
      S_NUM: begin
        anum_q <= num_c[NumW-1] ? NumW'(-num_c) : NumW'(num_c);
        aray_q <= side_q ? ary : arx;
      end
      S_ROWS: begin
        st_q    <= st_c;
        en_q    <= en_c;
        color_q <= wall_color(cell_q, side_q);
      end
      S_PLAN: begin
        for (int i = 0; i < 3; i++) begin
          rs_q[i] <= ps[i];
          re_q[i] <= pe[i];
          rc_q[i] <= pc[i];
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rect_push_o |-> !rect_full_i)
    else $error("result pushed into a full queue");
  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_o |-> !cmd_pop_o)
    else $error("request taken during clearing pass");
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK) |-> (int'(n_q) <= StepN))
    else $error("walk exceeded step limit");
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV_WAIT))
    else $error("divider finished outside a wait");
  a_plan_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PLAN) |=> (k_q != 2'd0 || idx_q == 2'd0))
    else $error("bad rectangle plan");
`endif

endmodule

// ===== src/grid_raycast_column_renderer.sv =====
// Flow: a map write is stored when the back takes its request from the command queue; a
// cast taken the same way holds the back through ray setup, the two reciprocal divisions,
// side setup, the walk of up to 2*MAP_SIZE = 64 cells, the line height division, row and
// plan setup, and the output of up to three results, which may stall on a full result queue.
// Throughput: one cast at a time; results leave at one per cycle while the queue has room.
// Reset: asynchronous, active low; a clearing pass zeroes map and stripe store while full
// stays high.
`timescale 1ns / 1ps
module grid_raycast_column_renderer
  import grc_pkg::*;
#(
  parameter int MAP_SIZE      = 32,
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [20:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic        action_i,
  input  logic [8:0]  column_i,
  input  logic [4:0]  cell_x_i,
  input  logic [4:0]  cell_y_i,
  input  logic [2:0]  cell_value_i,
  output logic        empty,
  input  logic        pop,
  output logic [8:0]  rect_x_start_o,
  output logic [8:0]  rect_x_end_o,
  output logic [7:0]  rect_y_start_o,
  output logic [7:0]  rect_y_end_o,
  output logic [15:0] fill_color_o,
  output logic        last_o
);
  cfg_t  cfg;
  cmd_t  cmd_in, cmd_out;
  rect_t rect_in, rect_out;
  logic  q_push, q_full, q_empty, q_pop, clearing;
  logic  r_push, r_full;

  grc_front #(
    .MAP_SIZE     (MAP_SIZE),
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cfg_o        (cfg),
    .push         (push),
    .full         (full),
    .action_i     (action_i),
    .column_i     (column_i),
    .cell_x_i     (cell_x_i),
    .cell_y_i     (cell_y_i),
    .cell_value_i (cell_value_i),
    .clearing_i   (clearing),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_data_o     (cmd_in)
  );

  grc_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (4)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (cmd_out),
    .empty_o (q_empty)
  );

  grc_back #(
    .MAP_SIZE      (MAP_SIZE),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd_out),
    .cmd_empty_i (q_empty),
    .cmd_pop_o   (q_pop),
    .rect_o      (rect_in),
    .rect_push_o (r_push),
    .rect_full_i (r_full),
    .clearing_o  (clearing)
  );

  grc_fifo #(
    .Width ($bits(rect_t)),
    .Depth (4)
  ) u_rect_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (r_push),
    .data_i  (rect_in),
    .full_o  (r_full),
    .pop_i   (pop),
    .data_o  (rect_out),
    .empty_o (empty)
  );

  assign rect_x_start_o = rect_out.x_start;
  assign rect_x_end_o   = rect_out.x_end;
  assign rect_y_start_o = rect_out.y_start;
  assign rect_y_end_o   = rect_out.y_end;
  assign fill_color_o   = rect_out.color;
  assign last_o         = rect_out.last;

endmodule

// ===== test/tb.sv =====
// Self-checking bench for the grid raycast column renderer: map writes, casts, camera setups.
`timescale 1ns / 1ps
module tb;
  import grc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [20:0] cfg_data_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic        action_i = 1'b0;
  logic [8:0]  column_i = '0;
  logic [4:0]  cell_x_i = '0;
  logic [4:0]  cell_y_i = '0;
  logic [2:0]  cell_value_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [8:0]  rect_x_start_o;
  logic [8:0]  rect_x_end_o;
  logic [7:0]  rect_y_start_o;
  logic [7:0]  rect_y_end_o;
  logic [15:0] fill_color_o;
  logic        last_o;

  grid_raycast_column_renderer dut (.*);

  localparam int MapN = 32;
  localparam int ScrW = 320;
  localparam int ScrH = 240;
  localparam int Drain = 2000;

  // Camera, map and stripe copies kept by the bench
  cfg_t        cam_q;
  logic [2:0]  map_q [MapN*MapN];
  int unsigned stripe_start_q [ScrW];
  int unsigned stripe_end_q [ScrW];
  logic [15:0] stripe_color_q [ScrW];

  cmd_t  request_q [$];
  rect_t rects_due_q [$];
  cmd_t  nxt;
  int    push_gap = 0;
  int    pop_gap = 0;
  bit    sent = 1'b0;
  bit    calm = 1'b0;
  int    errors = 0;

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic rect_t make_rect(int col, int unsigned ys, int unsigned ye,
                                      logic [15:0] color);
    rect_t r;
    r.x_start = col[8:0];
    r.x_end   = 9'(col + cam_q.stripe_width);
    r.y_start = ys[7:0];
    r.y_end   = ye[7:0];
    r.color   = color;
    r.last    = 1'b0;
    return r;
  endfunction

  function automatic void cast_ray(cmd_t c);
    longint inf, cm, rx, ry, arx, ary, mx, my, fx, fy, sx, sy;
    longint ddx, ddy, sdx, sdy, num, anum, aray, lh, ds, de;
    int unsigned st, en;
    int col;
    bit ys;
    logic [2:0] wall;
    logic [15:0] color;
    rect_t r [$];
    if (!c.is_cast) begin
      map_q[{c.cell_x, c.cell_y}] = c.value;
      return;
    end
    col = c.column;
    if (col >= ScrW) return;
    inf = longint'(1) << 62;
    cm = 2 * col - ScrW;
    rx = longint'($signed(cam_q.dir_x)) + (longint'($signed(cam_q.plane_x)) * cm) / ScrW;
    ry = longint'($signed(cam_q.dir_y)) + (longint'($signed(cam_q.plane_y)) * cm) / ScrW;
    arx = rx < 0 ? -rx : rx;
    ary = ry < 0 ? -ry : ry;
    mx = cam_q.pos_x[20:16];
    my = cam_q.pos_y[20:16];
    fx = cam_q.pos_x[15:0];
    fy = cam_q.pos_y[15:0];
    sx = rx < 0 ? -1 : 1;
    sy = ry < 0 ? -1 : 1;
    ddx = 0; ddy = 0; sdx = inf; sdy = inf;
    if (arx != 0) begin
      ddx = (longint'(1) << 30) / arx;
      sdx = ((rx < 0 ? fx : 65536 - fx) * ddx) >>> 16;
    end
    if (ary != 0) begin
      ddy = (longint'(1) << 30) / ary;
      sdy = ((ry < 0 ? fy : 65536 - fy) * ddy) >>> 16;
    end
    ys = 1'b0;
    wall = '0;
    for (int n = 0; n < 2 * MapN; n++) begin
      if (sdx < sdy) begin
        if (sdx != inf) sdx += ddx;
        mx += sx;
        ys = 1'b0;
      end else begin
        if (sdy != inf) sdy += ddy;
        my += sy;
        ys = 1'b1;
      end
      // off the map counts as a red wall
      if (mx < 0 || my < 0 || mx >= MapN || my >= MapN) wall = 3'd1;
      else wall = map_q[mx * MapN + my];
      if (wall != 0) break;
    end
    if (!ys) begin
      num = (mx + (sx < 0 ? 1 : 0)) * 65536 - longint'(cam_q.pos_x);
      aray = arx;
    end else begin
      num = (my + (sy < 0 ? 1 : 0)) * 65536 - longint'(cam_q.pos_y);
      aray = ary;
    end
    anum = num < 0 ? -num : num;
    if (aray == 0) lh = 0;
    else if (anum == 0) lh = 2 * ScrH;
    else begin
      lh = ScrH * aray * 4 / anum;
      if (lh > 2 * ScrH) lh = 2 * ScrH;
    end
    ds = ScrH / 2 - lh / 2;
    if (ds < 0) ds = 0;
    de = lh / 2 + ScrH / 2;
    if (de >= ScrH) de = ScrH - 1;
    st = 32'(ds);
    en = 32'(de);
    case (wall)
      3'd1:    color = ColorRed;
      3'd2:    color = ColorGreen;
      3'd3:    color = ColorBlue;
      3'd4:    color = ColorWhite;
      default: color = ColorYellow;
    endcase
    if (ys) color = color >> 1;

    if (stripe_start_q[col] == 0 && stripe_end_q[col] == 0) begin
      r.push_back(make_rect(col, st, en, color));
    end else if (stripe_color_q[col] != color) begin
      if (st <= stripe_start_q[col]) begin
        r.push_back(make_rect(col, st, en, color));
      end else begin
        r.push_back(make_rect(col, stripe_start_q[col], st, 16'h0));
        r.push_back(make_rect(col, st, en, color));
        r.push_back(make_rect(col, en, stripe_end_q[col], 16'h0));
      end
    end else begin
      // same color: grow in color, shrink in black, top then bottom
      if (st < stripe_start_q[col])
        r.push_back(make_rect(col, st, stripe_start_q[col], color));
      else if (st > stripe_start_q[col])
        r.push_back(make_rect(col, stripe_start_q[col], st, 16'h0));
      if (en < stripe_end_q[col])
        r.push_back(make_rect(col, en, stripe_end_q[col], 16'h0));
      else if (en > stripe_end_q[col])
        r.push_back(make_rect(col, stripe_end_q[col], en, color));
    end
    if (r.size() != 0) r[r.size() - 1].last = 1'b1;
    foreach (r[i]) rects_due_q.push_back(r[i]);
    stripe_start_q[col] = st;
    stripe_end_q[col] = en;
    stripe_color_q[col] = color;
  endfunction

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Accept side: update the copies at each handshake and check each popped result
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        REG_POS_X:    cam_q.pos_x = cfg_data_i;
        REG_POS_Y:    cam_q.pos_y = cfg_data_i;
        REG_DIR_X:    cam_q.dir_x = cfg_data_i[15:0];
        REG_DIR_Y:    cam_q.dir_y = cfg_data_i[15:0];
        REG_PLANE_X:  cam_q.plane_x = cfg_data_i[15:0];
        REG_PLANE_Y:  cam_q.plane_y = cfg_data_i[15:0];
        REG_STRIPE_W: cam_q.stripe_width = cfg_data_i[3:0];
        default: ;
      endcase
    end
    if (rst_ni && push && !full) begin
      cast_ray('{is_cast: action_i, column: column_i, cell_x: cell_x_i,
                 cell_y: cell_y_i, value: cell_value_i});
      sent = 1'b1;
    end
    if (rst_ni && pop && !empty) begin
      if (rects_due_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected rect %h", $time,
                 {rect_x_start_o, rect_x_end_o, rect_y_start_o, rect_y_end_o,
                  fill_color_o, last_o});
      end else begin
        rect_t e;
        e = rects_due_q.pop_front();
        if (e.x_start !== rect_x_start_o || e.x_end !== rect_x_end_o ||
            e.y_start !== rect_y_start_o || e.y_end !== rect_y_end_o ||
            e.color !== fill_color_o || e.last !== last_o) begin
          errors++;
          $display("%0t: rect mismatch exp x %0d..%0d y %0d..%0d c %h l %0b", $time,
                   e.x_start, e.x_end, e.y_start, e.y_end, e.color, e.last);
          $display("%0t:               got x %0d..%0d y %0d..%0d c %h l %0b", $time,
                   rect_x_start_o, rect_x_end_o, rect_y_start_o, rect_y_end_o,
                   fill_color_o, last_o);
        end
      end
      pop_gap = draw_gap();
    end
  end

  // Request driver
  always @(negedge clk_i) begin
    if (rst_ni && (!push || sent)) begin
      sent = 1'b0;
      if (push_gap > 0) begin
        push <= 1'b0;
        push_gap--;
      end else if (request_q.size() != 0) begin
        nxt = request_q.pop_front();
        action_i     <= nxt.is_cast;
        column_i     <= nxt.column;
        cell_x_i     <= nxt.cell_x;
        cell_y_i     <= nxt.cell_y;
        cell_value_i <= nxt.value;
        push <= 1'b1;
        push_gap = draw_gap();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result drain with random stalls unless calm is set
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (pop_gap > 0) begin
        pop <= 1'b0;
        pop_gap--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [20:0] d);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_camera(logic [20:0] px, logic [20:0] py, logic [20:0] dx,
                              logic [20:0] dy, logic [20:0] plx, logic [20:0] ply,
                              logic [20:0] sw);
    write_reg(REG_POS_X, px);
    write_reg(REG_POS_Y, py);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_PLANE_X, plx);
    write_reg(REG_PLANE_Y, ply);
    write_reg(REG_STRIPE_W, sw);
  endtask

  task automatic add_cell(int x, int y, int v);
    request_q.push_back('{is_cast: 1'b0, column: 9'($urandom), cell_x: x[4:0],
                          cell_y: y[4:0], value: v[2:0]});
  endtask

  task automatic add_cast(int col);
    request_q.push_back('{is_cast: 1'b1, column: col[8:0], cell_x: 5'($urandom),
                          cell_y: 5'($urandom), value: 3'($urandom)});
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 3)
        add_cell($urandom_range(0, 31), $urandom_range(0, 31),
                 $urandom_range(0, 1) ? 0 : $urandom_range(0, 7));
      else if ($urandom_range(0, 9) == 0)
        add_cast($urandom_range(0, 511));
      else
        add_cast($urandom_range(0, ScrW - 1));
    end
  endtask

  // Hold until all requests are in and every rect is out, then let the block settle
  task automatic drain();
    while (request_q.size() != 0 || push || rects_due_q.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  initial begin
    cam_q = '{pos_x: 21'd1441792, pos_y: 21'd786432, dir_x: -16'sd16384, dir_y: '0,
              plane_x: '0, plane_y: 16'sd10813, stripe_width: 4'd2};
    foreach (map_q[i]) map_q[i] = '0;
    foreach (stripe_start_q[i]) begin
      stripe_start_q[i] = 0;
      stripe_end_q[i] = 0;
      stripe_color_q[i] = '0;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Default camera: wall right next to the eye, zero ray y at the center column
    add_cell(21, 12, 2);
    add_cell(0, 0, 7);
    add_cell(31, 31, 7);
    add_cell(31, 0, 4);
    add_cell(0, 31, 3);
    add_cell(10, 21, 6);
    add_cast(160);
    add_cast(0);
    add_cast(319);
    add_cast(320);
    add_cast(511);
    add_cast(160);
    add_cell(21, 12, 5);
    add_cast(160);
    add_cell(21, 12, 0);
    add_cast(160);
    add_cast(100);
    add_cell(15, 10, 1);
    add_cast(100);
    add_cast(0);
    add_cast(319);
    drain();

    write_camera(21'd0, 21'd0, 21'h08000, 21'h08000, 21'h07FFF, 21'h07FFF, 21'd0);
    add_cast(0);
    add_cast(319);
    add_cast(160);
    add_random(30);
    drain();

    calm = 1'b1;
    write_camera(21'h1FFFFF, 21'h1FFFFF, 21'h07FFF, 21'h07FFF, 21'h08000, 21'h08000,
                 21'd15);
    add_cast(0);
    add_cast(319);
    add_random(30);
    drain();
    calm = 1'b0;

    // Inner cameras with moderate rays, then a fully random one
    for (int p = 0; p < 3; p++) begin
      write_camera(21'($urandom_range(2 << 16, 30 << 16)),
                   21'($urandom_range(2 << 16, 30 << 16)),
                   21'($signed(16'($urandom_range(0, 32767) - 16384))),
                   21'($signed(16'($urandom_range(0, 32767) - 16384))),
                   21'($signed(16'($urandom_range(0, 21000) - 10500))),
                   21'($signed(16'($urandom_range(0, 21000) - 10500))),
                   21'($urandom_range(1, 8)));
      add_random(35);
      drain();
    end
    write_camera(21'($urandom), 21'($urandom), 21'($urandom), 21'($urandom),
                 21'($urandom), 21'($urandom), 21'($urandom));
    add_random(25);
    drain();

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/grc_pkg.sv
src/grc_fifo.sv
src/grc_div.sv
src/grc_front.sv
src/grc_back.sv
src/grid_raycast_column_renderer.sv
test/tb.sv
